// ===== rtl/dpb_pkg.sv =====
// shared types, constants and register map of the depth pixel back-projection block
package dpb_pkg;

  // largest frame the counters can address
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // counter widths follow the frame limits
  localparam int COL_W = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CNT_W = (COL_W > ROW_W) ? COL_W : ROW_W;

  // register field widths
  localparam int SZ_W   = 13;
  localparam int CTR_W  = 13;
  localparam int RCP_W  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  // size compare width, holds any limit and any counter plus one
  localparam int LIM_W = 14;

  // signed half-pixel offset and its magnitude
  localparam int OFS_W = (((CNT_W + 1) > CTR_W) ? (CNT_W + 1) : CTR_W) + 1;
  localparam int MAG_W = OFS_W - 1;

  // magnitude times z, before the reciprocal
  localparam int T_W = MAG_W + 32;

  // queue depth between front and back
  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);

  // result queue depth
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_DEPTH_RECIP   = 3'd2,
    REG_CENTER_X2     = 3'd3,
    REG_CENTER_Y2     = 3'd4,
    REG_FOCAL_X_RECIP = 3'd5,
    REG_FOCAL_Y_RECIP = 3'd6
  } dpb_reg_t;

  // input transaction
  typedef struct packed {
    logic [15:0] depth_raw;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } dpb_in_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
  } dpb_out_t;

  // configuration register file
  typedef struct packed {
    logic [SZ_W-1:0]  image_width;
    logic [SZ_W-1:0]  image_height;
    logic [RCP_W-1:0] depth_recip;
    logic [CTR_W-1:0] center_x2;
    logic [CTR_W-1:0] center_y2;
    logic [RCP_W-1:0] focal_x_recip;
    logic [RCP_W-1:0] focal_y_recip;
  } dpb_cfg_t;

  localparam dpb_cfg_t CFG_RESET = '{
    image_width:   13'd640,
    image_height:  13'd480,
    depth_recip:   32'd4294967,
    center_x2:     13'd651,
    center_y2:     13'd507,
    focal_x_recip: 32'd8291443,
    focal_y_recip: 32'd8275467
  };

  // classified pixel handed from front to back
  typedef struct packed {
    logic [15:0]      depth_raw;
    logic             x_neg;
    logic [MAG_W-1:0] x_mag;
    logic             y_neg;
    logic [MAG_W-1:0] y_mag;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
  } dpb_work_t;

endpackage

// ===== rtl/dpb_regs.sv =====
// configuration register file with its write port
module dpb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dpb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::DATA_W-1:0]  cfg_data,
  output dpb_pkg::dpb_cfg_t           cfg
);

  dpb_pkg::dpb_cfg_t cfg_r;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register write decode, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= dpb_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpb_pkg::REG_IMAGE_WIDTH: begin
          cfg_r.image_width <= cfg_data[dpb_pkg::SZ_W-1:0];
        end
        dpb_pkg::REG_IMAGE_HEIGHT: begin
          cfg_r.image_height <= cfg_data[dpb_pkg::SZ_W-1:0];
        end
        dpb_pkg::REG_DEPTH_RECIP: begin
          cfg_r.depth_recip <= cfg_data[dpb_pkg::RCP_W-1:0];
        end
        dpb_pkg::REG_CENTER_X2: begin
          cfg_r.center_x2 <= cfg_data[dpb_pkg::CTR_W-1:0];
        end
        dpb_pkg::REG_CENTER_Y2: begin
          cfg_r.center_y2 <= cfg_data[dpb_pkg::CTR_W-1:0];
        end
        dpb_pkg::REG_FOCAL_X_RECIP: begin
          cfg_r.focal_x_recip <= cfg_data[dpb_pkg::RCP_W-1:0];
        end
        dpb_pkg::REG_FOCAL_Y_RECIP: begin
          cfg_r.focal_y_recip <= cfg_data[dpb_pkg::RCP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/dpb_front.sv =====
// front end: raster counters, zero-depth drop and offset classification
module dpb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  dpb_pkg::dpb_in_t    in_data,
  output logic                in_full,
  input  dpb_pkg::dpb_cfg_t   cfg,
  input  logic                mq_full,
  output logic                mq_push,
  output dpb_pkg::dpb_work_t  mq_data
);

  localparam int LIM_W = dpb_pkg::LIM_W;
  localparam int COL_W = dpb_pkg::COL_W;
  localparam int ROW_W = dpb_pkg::ROW_W;
  localparam int OFS_W = dpb_pkg::OFS_W;
  localparam int MAG_W = dpb_pkg::MAG_W;
  localparam logic [LIM_W-1:0] W_MAX = LIM_W'(dpb_pkg::MAX_WIDTH);
  localparam logic [LIM_W-1:0] H_MAX = LIM_W'(dpb_pkg::MAX_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [LIM_W-1:0] w_lim, h_lim, w_cfg, h_cfg, col_inc, row_inc;
  logic signed [OFS_W-1:0] dx, dy;
  logic             accept;

  assign in_full = mq_full;
  assign accept  = in_push && !mq_full;

  // effective frame size, zero acts as one and oversize clamps
  always_comb begin
    w_cfg = {{(LIM_W-dpb_pkg::SZ_W){1'b0}}, cfg.image_width};
    h_cfg = {{(LIM_W-dpb_pkg::SZ_W){1'b0}}, cfg.image_height};
    if (w_cfg == '0) begin
      w_lim = LIM_W'(1);
    end else if (w_cfg > W_MAX) begin
      w_lim = W_MAX;
    end else begin
      w_lim = w_cfg;
    end
    if (h_cfg == '0) begin
      h_lim = LIM_W'(1);
    end else if (h_cfg > H_MAX) begin
      h_lim = H_MAX;
    end else begin
      h_lim = h_cfg;
    end
  end

  // counter advance with wrap
  always_comb begin
    col_inc = {{(LIM_W-COL_W){1'b0}}, col_r} + LIM_W'(1);
    row_inc = {{(LIM_W-ROW_W){1'b0}}, row_r} + LIM_W'(1);
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_r;
    if (col_inc >= w_lim) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // half-pixel offsets from the principal point
  always_comb begin
    dx = $signed({{(OFS_W-COL_W-1){1'b0}}, col_r, 1'b0})
       - $signed({{(OFS_W-dpb_pkg::CTR_W){1'b0}}, cfg.center_x2});
    dy = $signed({{(OFS_W-ROW_W-1){1'b0}}, row_r, 1'b0})
       - $signed({{(OFS_W-dpb_pkg::CTR_W){1'b0}}, cfg.center_y2});
  end

  // sign and magnitude for the back end
  always_comb begin
    mq_data.depth_raw = in_data.depth_raw;
    mq_data.x_neg     = dx[OFS_W-1];
    mq_data.x_mag     = dx[OFS_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    mq_data.y_neg     = dy[OFS_W-1];
    mq_data.y_mag     = dy[OFS_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    mq_data.blue      = in_data.blue_in;
    mq_data.green     = in_data.green_in;
    mq_data.red       = in_data.red_in;
  end

  // zero depth advances the counters but is dropped
  assign mq_push = accept && (in_data.depth_raw != 16'd0);

endmodule

// ===== rtl/dpb_mid_queue.sv =====
// short queue of classified pixels between front and back
module dpb_mid_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dpb_pkg::dpb_work_t  push_data,
  output logic                full,
  input  logic                pop,
  output dpb_pkg::dpb_work_t  pop_data,
  output logic                empty
);

  localparam int PTR_W = dpb_pkg::MQ_PTR_W;
  localparam int CNT_W = PTR_W + 1;

  dpb_pkg::dpb_work_t mem_r [dpb_pkg::MQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(dpb_pkg::MQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_wr    = push && !full;
  assign do_rd    = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/dpb_back.sv =====
// back end: shared-multiplier sequencer for z, x, y and the result queue
module dpb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dpb_pkg::dpb_cfg_t   cfg,
  input  logic                mq_empty,
  input  dpb_pkg::dpb_work_t  mq_data,
  output logic                mq_pop,
  input  logic                out_pop,
  output dpb_pkg::dpb_out_t   out_data,
  output logic                out_empty
);

  localparam int MAG_W = dpb_pkg::MAG_W;
  localparam int T_W   = dpb_pkg::T_W;
  localparam int OQ_PW = dpb_pkg::OQ_PTR_W;
  localparam int OQ_CW = OQ_PW + 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ZMUL = 8'b0000_0010,
    ST_ZRND = 8'b0000_0100,
    ST_TMUL = 8'b0000_1000,
    ST_LMUL = 8'b0001_0000,
    ST_HMUL = 8'b0010_0000,
    ST_RND  = 8'b0100_0000,
    ST_PUSH = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic               axis_r, axis_nxt;
  dpb_pkg::dpb_work_t item_r;
  logic [31:0]        mul_a, mul_b, recip;
  logic [63:0]        prod_r;
  logic [31:0]        z_r, lo_r, coord, px_r, py_r;
  logic [T_W-1:0]     t_r, m;
  logic [T_W:0]       rsum;
  logic [48:0]        zsum;
  logic               neg, big;
  logic [MAG_W-1:0]   mag;

  dpb_pkg::dpb_out_t  oq_r [dpb_pkg::OQ_DEPTH];
  logic [OQ_PW-1:0]   oq_wr_r, oq_rd_r;
  logic [OQ_CW-1:0]   oq_cnt_r;
  logic               oq_full, oq_wr, oq_rd;
  dpb_pkg::dpb_out_t  res;

  // per-axis operand selection
  assign recip = axis_r ? cfg.focal_y_recip : cfg.focal_x_recip;
  assign mag   = axis_r ? item_r.y_mag : item_r.x_mag;
  assign neg   = axis_r ? item_r.y_neg : item_r.x_neg;

  // shared multiplier operands
  always_comb begin
    case (state_r)
      ST_ZMUL: begin
        mul_a = {16'd0, item_r.depth_raw};
        mul_b = cfg.depth_recip;
      end
      ST_TMUL: begin
        mul_a = {{(32-MAG_W){1'b0}}, mag};
        mul_b = z_r;
      end
      ST_LMUL: begin
        mul_a = prod_r[31:0];
        mul_b = recip;
      end
      ST_HMUL: begin
        mul_a = {{(32-MAG_W){1'b0}}, t_r[T_W-1:32]};
        mul_b = recip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // multiplier with registered product
  always_ff @(posedge clk) begin
    prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // z rounding and saturation
  assign zsum = {1'b0, prod_r[47:0]} + 49'h0_0000_0000_8000;

  // coordinate rounding: (hi + lo_word + 1) >> 1, then sign and saturation
  always_comb begin
    rsum = {1'b0, prod_r[T_W-1:0]} + {{(T_W+1-32){1'b0}}, lo_r} + (T_W+1)'(1);
    m    = rsum[T_W:1];
    big  = |m[T_W-1:31];
    if (neg) begin
      coord = big ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      coord = big ? 32'h7FFF_FFFF : m[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    mq_pop    = 1'b0;
    oq_wr     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!mq_empty) begin
          mq_pop    = 1'b1;
          axis_nxt  = 1'b0;
          state_nxt = ST_ZMUL;
        end
      end
      ST_ZMUL: begin
        state_nxt = ST_ZRND;
      end
      ST_ZRND: begin
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        state_nxt = ST_LMUL;
      end
      ST_LMUL: begin
        state_nxt = ST_HMUL;
      end
      ST_HMUL: begin
        state_nxt = ST_RND;
      end
      ST_RND: begin
        if (axis_r) begin
          state_nxt = ST_PUSH;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = ST_TMUL;
        end
      end
      ST_PUSH: begin
        if (!oq_full) begin
          oq_wr     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mq_pop) begin
      item_r <= mq_data;
    end
    if (state_r == ST_ZRND) begin
      z_r <= zsum[48] ? 32'hFFFF_FFFF : zsum[47:16];
    end
    if (state_r == ST_LMUL) begin
      t_r <= prod_r[T_W-1:0];
    end
    if (state_r == ST_HMUL) begin
      lo_r <= prod_r[63:32];
    end
    if (state_r == ST_RND) begin
      if (axis_r) begin
        py_r <= coord;
      end else begin
        px_r <= coord;
      end
    end
  end

  // result assembly from the captured coordinates
  always_comb begin
    res.point_x   = $signed(px_r);
    res.point_y   = $signed(py_r);
    res.point_z   = z_r;
    res.blue_out  = item_r.blue;
    res.green_out = item_r.green;
    res.red_out   = item_r.red;
  end

  // result queue
  assign oq_full   = (oq_cnt_r == OQ_CW'(dpb_pkg::OQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign oq_rd     = out_pop && !out_empty;
  assign out_data  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_wr) begin
        oq_wr_r <= oq_wr_r + OQ_PW'(1);
      end
      if (oq_rd) begin
        oq_rd_r <= oq_rd_r + OQ_PW'(1);
      end
      if (oq_wr && !oq_rd) begin
        oq_cnt_r <= oq_cnt_r + OQ_CW'(1);
      end else if (oq_rd && !oq_wr) begin
        oq_cnt_r <= oq_cnt_r - OQ_CW'(1);
      end
    end
  end

endmodule

// ===== rtl/depth_pixel_backprojection_top.sv =====
// top level of the depth pixel back-projection block
// a nonzero-depth pixel passes the front end, the front-to-back queue, the back end
// sequencer and the result queue; the sequencer runs z, x and y through one shared
// 32x32 multiplier and takes no new pixel until it has pushed its result; zero-depth
// pixels take one cycle each while the 4-entry queue between front and back has room
// reset: synchronous, restores register defaults, clears counters and empties the queues
module depth_pixel_backprojection_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  dpb_pkg::dpb_in_t            in_data,
  output logic                        in_full,
  input  logic                        out_pop,
  output dpb_pkg::dpb_out_t           out_data,
  output logic                        out_empty,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dpb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::DATA_W-1:0]  cfg_data
);

  dpb_pkg::dpb_cfg_t  cfg;
  dpb_pkg::dpb_work_t mq_wdata, mq_rdata;
  logic               mq_push, mq_full, mq_pop, mq_empty;

  // configuration registers
  dpb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pixel intake and classification
  dpb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .cfg     (cfg),
    .mq_full (mq_full),
    .mq_push (mq_push),
    .mq_data (mq_wdata)
  );

  // decoupling queue
  dpb_mid_queue u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_data (mq_wdata),
    .full      (mq_full),
    .pop       (mq_pop),
    .pop_data  (mq_rdata),
    .empty     (mq_empty)
  );

  // projection and result queue
  dpb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mq_empty  (mq_empty),
    .mq_data   (mq_rdata),
    .mq_pop    (mq_pop),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

endmodule

// ===== rtl/dpb_checker.sv =====
// port-level checker for the depth pixel back-projection block, with its bind
module dpb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_pop,
  input dpb_pkg::dpb_out_t out_data,
  input logic              out_empty
);

  // reset leaves no result and room for input
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // input side fills only through an accepted transaction
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("in_full rose without an accepted transaction");

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result withdrawn before pop");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_data  (out_data),
  .out_empty (out_empty)
);

// ===== tb/depth_pixel_backprojection_top_test.sv =====
// self-checking testbench for the depth pixel back-projection block
module depth_pixel_backprojection_top_test;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BLOCK_ITEMS   = 56;
  localparam int IDX_W         = dpb_pkg::IDX_W;
  localparam int DATA_W        = dpb_pkg::DATA_W;
  localparam int SZ_W          = dpb_pkg::SZ_W;
  localparam int CTR_W         = dpb_pkg::CTR_W;
  // index with no register behind it
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_push   = 1'b0;
  dpb_pkg::dpb_in_t   in_data   = '0;
  logic               in_full;
  logic               out_pop   = 1'b0;
  dpb_pkg::dpb_out_t  out_data;
  logic               out_empty;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data  = '0;

  // shadow registers and raster position
  dpb_pkg::dpb_cfg_t cfg_shadow = dpb_pkg::CFG_RESET;
  int       col_cnt    = 0;
  int       row_cnt    = 0;

  // points still owed by the block, oldest first
  dpb_pkg::dpb_out_t point_q[$];
  dpb_pkg::dpb_out_t want_pt;

  int err_count     = 0;
  int pixel_count   = 0;
  int point_count   = 0;
  int setup_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  depth_pixel_backprojection_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // effective frame size: zero acts as one, oversize clamps to the maximum
  function automatic int frame_limit(logic [SZ_W-1:0] v, int max_size);
    if (v == 0) return 1;
    return (v > max_size) ? max_size : int'(v);
  endfunction

  // half-pixel offset times z times reciprocal focal length, rounded and saturated
  function automatic logic [31:0] project_offset(int offs, logic [31:0] z,
                                                 logic [31:0] recip);
    logic [79:0] mag;
    logic [79:0] prod;
    logic [79:0] rounded;
    mag     = 80'((offs < 0) ? -offs : offs);
    prod    = mag * z * recip;
    rounded = (prod + (80'd1 << 32)) >> 33;
    if (offs < 0)
      return (rounded >= 80'h8000_0000) ? 32'h8000_0000 : 32'h0 - rounded[31:0];
    return (rounded > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : rounded[31:0];
  endfunction

  // 3-d point for a nonzero-depth pixel at the current raster position
  function automatic dpb_pkg::dpb_out_t predict_point(dpb_pkg::dpb_in_t px);
    dpb_pkg::dpb_out_t pt;
    logic [48:0] z_full;
    logic [32:0] z_round;
    logic [31:0] z;
    int          cx;
    int          cy;
    z_full  = px.depth_raw * cfg_shadow.depth_recip + 49'd32768;
    z_round = z_full[48:16];
    z       = z_round[32] ? 32'hFFFF_FFFF : z_round[31:0];
    cx      = int'(cfg_shadow.center_x2);
    cy      = int'(cfg_shadow.center_y2);
    pt.point_x   = project_offset(2 * col_cnt - cx, z, cfg_shadow.focal_x_recip);
    pt.point_y   = project_offset(2 * row_cnt - cy, z, cfg_shadow.focal_y_recip);
    pt.point_z   = z;
    pt.blue_out  = px.blue_in;
    pt.green_out = px.green_in;
    pt.red_out   = px.red_in;
    return pt;
  endfunction

  // random register values, extremes mixed in
  function automatic logic [DATA_W-1:0] pick_size();
    logic [SZ_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 13'd1;
      2: v = 13'd4096;
      3: v = 13'h1FFF;
      default: v = 13'($urandom_range(40, 2));
    endcase
    return ({$urandom} & 32'hFFFF_E000) | {{(DATA_W-SZ_W){1'b0}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] pick_center();
    logic [CTR_W-1:0] v;
    case ($urandom_range(5))
      0: v = '0;
      1: v = 13'h1FFF;
      2, 3: v = 13'($urandom_range(80));
      default: v = 13'($urandom);
    endcase
    return ({$urandom} & 32'hFFFF_E000) | {{(DATA_W-CTR_W){1'b0}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] pick_recip();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(32'h0100_0000);
    endcase
  endfunction

  // one register write transaction; valid stays high unless this is the last one
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dpb_pkg::REG_IMAGE_WIDTH:   cfg_shadow.image_width   = val[SZ_W-1:0];
      dpb_pkg::REG_IMAGE_HEIGHT:  cfg_shadow.image_height  = val[SZ_W-1:0];
      dpb_pkg::REG_DEPTH_RECIP:   cfg_shadow.depth_recip   = val;
      dpb_pkg::REG_CENTER_X2:     cfg_shadow.center_x2     = val[CTR_W-1:0];
      dpb_pkg::REG_CENTER_Y2:     cfg_shadow.center_y2     = val[CTR_W-1:0];
      dpb_pkg::REG_FOCAL_X_RECIP: cfg_shadow.focal_x_recip = val;
      dpb_pkg::REG_FOCAL_Y_RECIP: cfg_shadow.focal_y_recip = val;
      default: ;
    endcase
    if (last) begin
      cfg_valid <= 1'b0;
      setup_count++;
    end
  endtask

  // push one pixel, record its point and step the raster counters
  task automatic push_pixel(input dpb_pkg::dpb_in_t px);
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    pixel_count++;
    if (px.depth_raw != 0) point_q.insert(point_q.size(), predict_point(px));
    if (col_cnt + 1 >= frame_limit(cfg_shadow.image_width, dpb_pkg::MAX_WIDTH)) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= frame_limit(cfg_shadow.image_height,
                                            dpb_pkg::MAX_HEIGHT)) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    // sender gap
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // let every owed point drain, then give trailing zero-depth pixels time to clear
  task automatic settle();
    in_push <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset defaults, depth and colour extremes, zero depth
  task automatic test_reset_defaults();
    push_pixel({16'd1, 8'h00, 8'h00, 8'h00});
    push_pixel({16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
    push_pixel({16'd0, 8'hA5, 8'h5A, 8'hC3});
    push_pixel({16'd1000, 8'h5A, 8'hC3, 8'h3C});
    push_pixel({16'h8000, 8'h01, 8'h80, 8'h7F});
    settle();
  endtask

  // zero width, one-row frame, maximum reciprocals, negative saturation, zero z
  task automatic test_config_extremes();
    write_reg(dpb_pkg::REG_IMAGE_WIDTH, 32'hFFFF_E000, 0);
    write_reg(dpb_pkg::REG_IMAGE_HEIGHT, 32'd1, 0);
    write_reg(dpb_pkg::REG_DEPTH_RECIP, 32'hFFFF_FFFF, 0);
    write_reg(dpb_pkg::REG_CENTER_X2, 32'h1FFF, 0);
    write_reg(dpb_pkg::REG_CENTER_Y2, 32'h0, 0);
    write_reg(dpb_pkg::REG_FOCAL_X_RECIP, 32'hFFFF_FFFF, 0);
    write_reg(dpb_pkg::REG_FOCAL_Y_RECIP, 32'hFFFF_FFFF, 1);
    push_pixel({16'hFFFF, 8'hFF, 8'h00, 8'hFF});
    push_pixel({16'd1, 8'h00, 8'hFF, 8'h00});
    push_pixel({16'd2, 8'h55, 8'hAA, 8'h55});
    settle();
    write_reg(dpb_pkg::REG_DEPTH_RECIP, 32'h0, 1);
    push_pixel({16'hFFFF, 8'hAA, 8'h55, 8'hAA});
    settle();
  endtask

  // oversize width register clamps to the maximum, full-scale focal reciprocal
  task automatic test_oversize_frame();
    write_reg(dpb_pkg::REG_IMAGE_WIDTH, 32'h1FFF, 0);
    write_reg(dpb_pkg::REG_IMAGE_HEIGHT, 32'd4096, 0);
    write_reg(dpb_pkg::REG_DEPTH_RECIP, 32'd4294967, 0);
    write_reg(dpb_pkg::REG_CENTER_X2, 32'h0, 0);
    write_reg(dpb_pkg::REG_CENTER_Y2, 32'd1, 0);
    write_reg(dpb_pkg::REG_FOCAL_X_RECIP, 32'hFFFF_FFFF, 0);
    write_reg(dpb_pkg::REG_FOCAL_Y_RECIP, 32'd8275467, 1);
    push_pixel({16'hFFFF, 8'h12, 8'h34, 8'h56});
    push_pixel({16'd777, 8'h9A, 8'hBC, 8'hDE});
    push_pixel({16'd4321, 8'hF0, 8'h0F, 8'hE1});
    settle();
  endtask

  // shrink width, then shrink height while the row counter sits beyond the new height
  task automatic test_resize_mid_frame();
    write_reg(dpb_pkg::REG_IMAGE_WIDTH, 32'd6, 0);
    write_reg(dpb_pkg::REG_IMAGE_HEIGHT, 32'd4, 0);
    write_reg(dpb_pkg::REG_CENTER_X2, 32'd3, 0);
    write_reg(dpb_pkg::REG_CENTER_Y2, 32'd2, 0);
    write_reg(dpb_pkg::REG_FOCAL_X_RECIP, 32'd8291443, 1);
    repeat (3) push_pixel({16'($urandom_range(65535, 1)), 24'($urandom)});
    settle();
    write_reg(dpb_pkg::REG_IMAGE_WIDTH, 32'd3, 1);
    repeat (3) push_pixel({16'($urandom_range(65535, 1)), 24'($urandom)});
    settle();
    write_reg(dpb_pkg::REG_IMAGE_HEIGHT, 32'd2, 1);
    repeat (3) push_pixel({16'($urandom_range(65535, 1)), 24'($urandom)});
    settle();
  endtask

  // a write to an unused index must change nothing
  task automatic test_unused_index();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF, 1);
    push_pixel({16'd1500, 8'h11, 8'h22, 8'h33});
    push_pixel({16'd65000, 8'hEE, 8'hDD, 8'hCC});
    settle();
  endtask

  // random settings and pixels under the given sender and receiver idling
  task automatic test_random_traffic(input int send_pct, input int stall_pct);
    dpb_pkg::dpb_in_t px;
    int      pick;
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
    repeat (2) begin
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom, 0);
      write_reg(dpb_pkg::REG_IMAGE_WIDTH, pick_size(), 0);
      write_reg(dpb_pkg::REG_IMAGE_HEIGHT, pick_size(), 0);
      write_reg(dpb_pkg::REG_DEPTH_RECIP, pick_recip(), 0);
      write_reg(dpb_pkg::REG_CENTER_X2, pick_center(), 0);
      write_reg(dpb_pkg::REG_CENTER_Y2, pick_center(), 0);
      write_reg(dpb_pkg::REG_FOCAL_X_RECIP, pick_recip(), 0);
      write_reg(dpb_pkg::REG_FOCAL_Y_RECIP, pick_recip(), 1);
      repeat (BLOCK_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 20)      px.depth_raw = '0;
        else if (pick < 30) px.depth_raw = 16'($urandom_range(15, 1));
        else if (pick < 40) px.depth_raw = 16'hFFFF - 16'($urandom_range(15));
        else                px.depth_raw = 16'($urandom_range(65535, 1));
        px.blue_in  = 8'($urandom);
        px.green_in = 8'($urandom);
        px.red_in   = 8'($urandom);
        push_pixel(px);
      end
      settle();
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // result side: random stalls, check each popped point against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (point_q.size() == 0) begin
        err_count++;
        $display("%0t unexpected point: expected none, actual %h", $time, out_data);
      end else begin
        want_pt = point_q.pop_front();
        point_count++;
        compare_field("point_x", want_pt.point_x, out_data.point_x);
        compare_field("point_y", want_pt.point_y, out_data.point_y);
        compare_field("point_z", want_pt.point_z, out_data.point_z);
        compare_field("blue_out", 32'(want_pt.blue_out), 32'(out_data.blue_out));
        compare_field("green_out", 32'(want_pt.green_out), 32'(out_data.green_out));
        compare_field("red_out", 32'(want_pt.red_out), 32'(out_data.red_out));
      end
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // cycle counter and timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t timeout after %0d cycles, %0d points still owed",
             $time, cycle_count, point_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_config_extremes();
    test_oversize_frame();
    test_resize_mid_frame();
    test_unused_index();
    test_random_traffic(0, 0);
    test_random_traffic(58, 0);
    test_random_traffic(0, 58);
    test_random_traffic(35, 35);
    $display("pushed %0d pixels, checked %0d points over %0d register settings",
             pixel_count, point_count, setup_count);
    $display("phases: no idling, sender gaps, receiver stalls, both together");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
